// File: rtl/core/bcs_pkg.sv
`timescale 1ns / 1ps
package bcs_pkg;
   localparam int MAX_SPHERES_DEF = 1024;
   localparam int COORD_BITS_DEF  = 24;
endpackage

// File: rtl/core/bcs_if.sv
`timescale 1ns / 1ps
interface bcs_req_if #(parameter int COORD_BITS = bcs_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] center_x;
   logic signed [COORD_BITS-1:0] center_y;
   logic signed [COORD_BITS-1:0] center_z;
   logic        [COORD_BITS-2:0] sphere_radius;
   logic                         is_last;
   modport source (output valid, center_x, center_y, center_z, sphere_radius, is_last,
                   input ready);
   modport sink   (input valid, center_x, center_y, center_z, sphere_radius, is_last,
                   output ready);
endinterface

interface bcs_rsp_if #(parameter int COORD_BITS = bcs_pkg::COORD_BITS_DEF);
   logic                       valid;
   logic                       ready;
   logic signed [COORD_BITS:0] enclose_x;
   logic signed [COORD_BITS:0] enclose_y;
   logic signed [COORD_BITS:0] enclose_z;
   logic [COORD_BITS+1:0]      enclose_radius;
   logic                       overflowed;
   modport source (output valid, enclose_x, enclose_y, enclose_z, enclose_radius, overflowed,
                   input ready);
   modport sink   (input valid, enclose_x, enclose_y, enclose_z, enclose_radius, overflowed,
                   output ready);
endinterface

// File: rtl/core/bcs_sqrt.sv
`timescale 1ns / 1ps
// Pipelined integer square root, one root bit per stage, rounded up.
module bcs_sqrt #(
   parameter int N  = bcs_pkg::COORD_BITS_DEF + 2,
   parameter int PW = bcs_pkg::COORD_BITS_DEF - 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   input  logic [2*N-1:0]  in_value,
   input  logic [PW-1:0]   in_tag,
   output logic            out_valid,
   output logic [N:0]      out_root,
   output logic [PW-1:0]   out_tag
);
   logic [N+1:0]   rem_w [0:N];
   logic [N-1:0]   root_w [0:N];
   logic [2*N-1:0] val_w [0:N];
   logic [PW-1:0]  tag_w [0:N];
   logic           vld_w [0:N];

   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign val_w[0]  = in_value;
   assign tag_w[0]  = in_tag;
   assign vld_w[0]  = in_valid;

   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [N+3:0]   shifted;
      logic [N+3:0]   trial;
      logic           take;
      logic [N+1:0]   rem_ff;
      logic [N-1:0]   root_ff;
      logic [2*N-1:0] val_ff;
      logic [PW-1:0]  tag_ff;
      logic           vld_ff;

      assign shifted = {rem_w[k], val_w[k][2*N-1 -: 2]};
      assign trial   = {2'b00, root_w[k], 2'b01};
      assign take    = shifted >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else begin
            vld_ff <= vld_w[k];
         end
         rem_ff  <= take ? (shifted[N+1:0] - trial[N+1:0]) : shifted[N+1:0];
         root_ff <= {root_w[k][N-2:0], take};
         val_ff  <= {val_w[k][2*N-3:0], 2'b00};
         tag_ff  <= tag_w[k];
      end

      assign rem_w[k+1]  = rem_ff;
      assign root_w[k+1] = root_ff;
      assign val_w[k+1]  = val_ff;
      assign tag_w[k+1]  = tag_ff;
      assign vld_w[k+1]  = vld_ff;
   end

   // a nonzero remainder means root^2 fell short of the input
   assign out_root  = {1'b0, root_w[N]} + {{N{1'b0}}, (rem_w[N] != '0)};
   assign out_tag   = tag_w[N];
   assign out_valid = vld_w[N];
endmodule

// File: rtl/core/box_center_enclosing_sphere.sv
`timescale 1ns / 1ps
// Load: one sphere beat per cycle into the sphere memory while it has room, box kept
// in registers. Final pass: n reads, one per cycle, through diff/square/sum stages
// and a COORD_BITS+2 stage square-root pipeline; the result beat follows once all n
// distances are done (n = stored spheres).
// No input is taken from the last beat until the result beat is taken.
// Reset (synchronous): empty set, empty box, no drop; memory contents are not cleared.
module box_center_enclosing_sphere #(
   parameter int MAX_SPHERES = bcs_pkg::MAX_SPHERES_DEF,
   parameter int COORD_BITS  = bcs_pkg::COORD_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bcs_req_if.sink     req,
   bcs_rsp_if.source   rsp
);
   localparam int CB = COORD_BITS;
   localparam int N  = CB + 2;
   localparam int CW = $clog2(MAX_SPHERES + 1);
   localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
   localparam int MW = 4 * CB - 1;

   typedef enum logic [1:0] {LOAD, MID, PASS, RESULT} state_type;

   state_type          state_ff;
   logic [CW-1:0]      cnt_ff;
   logic               drop_ff;
   logic signed [CB:0] lo_ff [0:2];
   logic signed [CB:0] hi_ff [0:2];
   logic signed [CB:0] mid_ff [0:2];
   logic [CW-1:0]      rd_idx_ff;
   logic [CW-1:0]      done_ff;
   logic [N+1:0]       best_ff;
   logic [N-1:0]       rad_out_ff;

   logic [MW-1:0]      mem [0:MAX_SPHERES-1];
   logic [MW-1:0]      rdata_ff;
   logic               v1_ff, v2_ff, v3_ff, v4_ff;

   logic               req_fire, rsp_fire, room, rd_en;
   logic signed [CB:0] cen [0:2];
   logic signed [CB:0] lo_in [0:2];
   logic signed [CB:0] hi_in [0:2];
   logic signed [CB+1:0] mid_sum [0:2];

   assign req.ready = (state_ff == LOAD);
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;
   assign room      = cnt_ff < CW'(MAX_SPHERES);
   assign rd_en     = (state_ff == PASS) && (rd_idx_ff < cnt_ff);

   assign cen[0] = {req.center_x[CB-1], req.center_x};
   assign cen[1] = {req.center_y[CB-1], req.center_y};
   assign cen[2] = {req.center_z[CB-1], req.center_z};

   for (genvar a = 0; a < 3; a++) begin : g_box
      logic signed [CB:0] c_lo, c_hi;
      assign c_lo = cen[a] - $signed({2'b00, req.sphere_radius});
      assign c_hi = cen[a] + $signed({2'b00, req.sphere_radius});
      assign lo_in[a] = (c_lo < lo_ff[a]) ? c_lo : lo_ff[a];
      assign hi_in[a] = (c_hi > hi_ff[a]) ? c_hi : hi_ff[a];
      assign mid_sum[a] = {lo_ff[a][CB], lo_ff[a]} + {hi_ff[a][CB], hi_ff[a]};
   end

   // control and registered result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LOAD;
         cnt_ff   <= '0;
         drop_ff  <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            lo_ff[a] <= {1'b0, {CB{1'b1}}};
            hi_ff[a] <= {1'b1, {CB{1'b0}}};
         end
      end else begin
         unique case (state_ff)
            LOAD: begin
               if (req_fire) begin
                  if (room) begin
                     cnt_ff <= cnt_ff + 1'b1;
                     for (int a = 0; a < 3; a++) begin
                        lo_ff[a] <= lo_in[a];
                        hi_ff[a] <= hi_in[a];
                     end
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (req.is_last) state_ff <= MID;
               end
            end
            MID: begin
               for (int a = 0; a < 3; a++) mid_ff[a] <= mid_sum[a][CB+1:1];
               state_ff <= PASS;
            end
            PASS: begin
               if (done_ff == cnt_ff) begin
                  rad_out_ff <= (|best_ff[N+1:N]) ? {N{1'b1}} : best_ff[N-1:0];
                  state_ff   <= RESULT;
               end
            end
            RESULT: begin
               if (rsp_fire) begin
                  cnt_ff  <= '0;
                  drop_ff <= 1'b0;
                  for (int a = 0; a < 3; a++) begin
                     lo_ff[a] <= {1'b0, {CB{1'b1}}};
                     hi_ff[a] <= {1'b1, {CB{1'b0}}};
                  end
                  state_ff <= LOAD;
               end
            end
            default: state_ff <= LOAD;
         endcase
      end
   end

   // sphere memory
   always_ff @(posedge clock) begin
      if (req_fire && room)
         mem[cnt_ff[AW-1:0]] <= {req.center_x, req.center_y, req.center_z, req.sphere_radius};
      if (rd_en)
         rdata_ff <= mem[rd_idx_ff[AW-1:0]];
   end

   // distance pipeline
   logic [CB:0]        d_ff [0:2];
   logic [CB-2:0]      r2_ff, r3_ff, r4_ff;
   logic [2*CB+1:0]    sq_ff [0:2];
   logic [2*N-1:0]     sum_ff;
   logic               sq_valid;
   logic [N:0]         sq_root;
   logic [CB-2:0]      sq_rad;
   logic [N+1:0]       dist_in;
   logic signed [CB+1:0] diff [0:2];
   logic [CB+1:0]      mag [0:2];

   for (genvar a = 0; a < 3; a++) begin : g_diff
      logic signed [CB-1:0] s;
      assign s = rdata_ff[MW-1-a*CB -: CB];
      assign diff[a] = {mid_ff[a][CB], mid_ff[a]} - {{2{s[CB-1]}}, s};
      assign mag[a]  = diff[a][CB+1] ? -diff[a] : diff[a];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= rd_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      for (int a = 0; a < 3; a++) begin
         d_ff[a]  <= mag[a][CB:0];
         sq_ff[a] <= d_ff[a] * d_ff[a];
      end
      r2_ff  <= rdata_ff[CB-2:0];
      r3_ff  <= r2_ff;
      r4_ff  <= r3_ff;
      sum_ff <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
   end

   bcs_sqrt #(.N(N), .PW(CB - 1)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_value  (sum_ff),
      .in_tag    (r4_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_tag   (sq_rad)
   );

   assign dist_in = {1'b0, sq_root} + {5'b0, sq_rad};

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff <= '0;
         done_ff   <= '0;
         best_ff   <= '0;
      end else if (state_ff == MID) begin
         rd_idx_ff <= '0;
         done_ff   <= '0;
         best_ff   <= '0;
      end else begin
         if (rd_en) rd_idx_ff <= rd_idx_ff + 1'b1;
         if (sq_valid) begin
            done_ff <= done_ff + 1'b1;
            if (dist_in > best_ff) best_ff <= dist_in;
         end
      end
   end

   assign rsp.valid          = (state_ff == RESULT);
   assign rsp.enclose_x      = mid_ff[0];
   assign rsp.enclose_y      = mid_ff[1];
   assign rsp.enclose_z      = mid_ff[2];
   assign rsp.enclose_radius = rad_out_ff;
   assign rsp.overflowed     = drop_ff;

   a_rd_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PASS) |-> (rd_idx_ff <= cnt_ff))
      else $error("read index ran past the stored count");
   a_done_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PASS) |-> (done_ff <= rd_idx_ff))
      else $error("more distances finished than were issued");
   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req.is_last) |=> !req.ready)
      else $error("input taken after last beat");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |=> (cnt_ff == '0) && !drop_ff)
      else $error("set not cleared after result beat");
endmodule
